// ----- rtl/tree_lca_binary_lifting_macros.svh -----
// Assertion macros for the RTL of the lowest common ancestor block.
// Depends on nothing; files that assert include it inside a module body.
`ifndef TREE_LCA_BINARY_LIFTING_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_MACROS_SVH

// Same-cycle implication under the synchronous active-low reset.
`define TLCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the synchronous active-low reset.
`define TLCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tlca_pkg.sv -----
// Shared types and constants of the lowest common ancestor block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tlca_pkg;
    localparam int NODE_W = 11;
    localparam int CMD_W  = 2;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CMD_W-1:0]  t_cmd;

    localparam t_cmd CMD_ADD_EDGE = 2'd0;
    localparam t_cmd CMD_BUILD    = 2'd1;
    localparam t_cmd CMD_QUERY    = 2'd2;
    localparam t_cmd CMD_NONE     = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/tlca_if.sv -----
// Valid/ready channel interfaces for the command input and the result output.
// Depends on tlca_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tlca_in_if import tlca_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_node node_a;
    t_node node_b;

    modport source (output valid, output cmd, output node_a, output node_b, input ready);
    modport sink   (input valid, input cmd, input node_a, input node_b, output ready);
endinterface

interface tlca_out_if import tlca_pkg::*; ();
    logic  valid;
    logic  ready;
    t_node ancestor;

    modport source (output valid, output ancestor, input ready);
    modport sink   (input valid, input ancestor, output ready);
endinterface
`default_nettype wire

// ----- rtl/tlca_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/tree_lca_binary_lifting.sv -----
// Lowest common ancestor by binary lifting over a tree rooted at node 1. Edge items
// are taken in the idle state. A build item first sweeps the node and ancestor
// memories (the same sweep runs once after reset, during which no item is taken),
// then walks the tree breadth first, then fills each ancestor level. A query runs
// a chain of ancestor-row reads through the one read port of the ancestor memory,
// one row per lift step and two rows per climb step, and then waits until the
// output register is free.
// Depends on tlca_pkg, tlca_if, tlca_ram and the macros header.
`timescale 1ns / 1ps
`default_nettype none
module tree_lca_binary_lifting import tlca_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire t_node       i_cfg_wr_data,
    tlca_in_if.sink          i_req,
    tlca_out_if.source       o_rsp
);
    localparam int AW   = $clog2(MAX_NODES + 1);
    localparam int DW   = $clog2(MAX_NODES);
    localparam int EW   = $clog2(MAX_NODES);
    localparam int EAW  = (MAX_NODES > 2) ? $clog2(MAX_NODES - 1) : 1;
    localparam int QAW  = $clog2(MAX_NODES);
    localparam int QCW  = $clog2(MAX_NODES + 1);
    localparam int LWI  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LJW  = $clog2(LEVELS + 1);
    localparam int RW   = LEVELS * NODE_W;
    localparam int CMPW = ((DW > LEVELS) ? DW : LEVELS) + 1;
    localparam int SHW  = NODE_W + 6;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLR   = 5'd1;
    localparam logic [4:0] S_ROOT  = 5'd2;
    localparam logic [4:0] S_POP   = 5'd3;
    localparam logic [4:0] S_X1    = 5'd4;
    localparam logic [4:0] S_X2    = 5'd5;
    localparam logic [4:0] S_E     = 5'd6;
    localparam logic [4:0] S_E1    = 5'd7;
    localparam logic [4:0] S_E2    = 5'd8;
    localparam logic [4:0] S_FJ    = 5'd9;
    localparam logic [4:0] S_FI    = 5'd10;
    localparam logic [4:0] S_F1    = 5'd11;
    localparam logic [4:0] S_F2    = 5'd12;
    localparam logic [4:0] S_QB    = 5'd13;
    localparam logic [4:0] S_QC    = 5'd14;
    localparam logic [4:0] S_QT    = 5'd15;
    localparam logic [4:0] S_LIFT  = 5'd16;
    localparam logic [4:0] S_LWAIT = 5'd17;
    localparam logic [4:0] S_EQ    = 5'd18;
    localparam logic [4:0] S_CLIMB = 5'd19;
    localparam logic [4:0] S_CW1   = 5'd20;
    localparam logic [4:0] S_CW2   = 5'd21;
    localparam logic [4:0] S_QEND  = 5'd22;
    localparam logic [4:0] S_QDONE = 5'd23;

    logic [4:0]    r_state;
    t_node         r_node_count;
    logic [EW-1:0] r_edges;
    logic [AW-1:0] r_ci;
    logic          r_walk;
    logic [QCW-1:0] r_head, r_tail;
    t_node         r_x, r_y;
    logic [DW-1:0] r_dx;
    logic [EW-1:0] r_e;
    logic [LJW-1:0] r_fj;
    logic [NODE_W:0] r_fi;
    logic [RW-1:0] r_row_u, r_row_v;
    t_node         r_u, r_v;
    logic [DW-1:0] r_du, r_dv;
    logic [LWI-1:0] r_top, r_qi;
    logic          r_fin;
    t_node         r_res;
    logic          r_out_valid;
    t_node         r_out_anc;

    // memory ports
    logic             w_nd_we;
    logic [AW-1:0]    w_nd_waddr, w_nd_raddr;
    logic [DW:0]      w_nd_wdata, w_nd_rdata;
    logic             w_lt_we;
    logic [AW-1:0]    w_lt_waddr, w_lt_raddr;
    logic [RW-1:0]    w_lt_wdata, w_lt_rdata;
    logic             w_q_we;
    logic [QAW-1:0]   w_q_waddr, w_q_raddr;
    t_node            w_q_wdata, w_q_rdata;
    logic             w_e_we;
    logic [EAW-1:0]   w_e_waddr, w_e_raddr;
    logic [2*NODE_W-1:0] w_e_wdata, w_e_rdata;

    t_node  w_n;
    logic   w_acc;
    logic   w_q_bad;
    t_node  w_ea, w_eb, w_ey;
    logic   w_e_ok;
    logic   w_push;
    t_node  w_up, w_pu, w_pv, w_mid, w_fmid;
    logic [CMPW-1:0] w_step;
    logic   w_lift_go;
    logic   w_climb_go;
    logic [LWI-1:0] w_log;
    logic [RW-1:0]  w_fill_row;

    function automatic t_node row_field(input logic [RW-1:0] row, input logic [LWI-1:0] k);
        return row[NODE_W*k +: NODE_W];
    endfunction

    function automatic logic [LWI-1:0] top_level(input logic [DW-1:0] d);
        int t;
        t = 0;
        for (int k = 1; k < DW; k++) begin
            if (d[k]) t = k;
        end
        if (t > LEVELS - 1) t = LEVELS - 1;
        return LWI'(t);
    endfunction

    tlca_ram #(.WIDTH(DW + 1), .DEPTH(MAX_NODES + 1)) u_node_ram (
        .i_clk(i_clk), .i_wr_en(w_nd_we), .i_wr_addr(w_nd_waddr), .i_wr_data(w_nd_wdata),
        .i_rd_addr(w_nd_raddr), .o_rd_data(w_nd_rdata)
    );
    tlca_ram #(.WIDTH(RW), .DEPTH(MAX_NODES + 1)) u_lift_ram (
        .i_clk(i_clk), .i_wr_en(w_lt_we), .i_wr_addr(w_lt_waddr), .i_wr_data(w_lt_wdata),
        .i_rd_addr(w_lt_raddr), .o_rd_data(w_lt_rdata)
    );
    tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk(i_clk), .i_wr_en(w_q_we), .i_wr_addr(w_q_waddr), .i_wr_data(w_q_wdata),
        .i_rd_addr(w_q_raddr), .o_rd_data(w_q_rdata)
    );
    tlca_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_NODES - 1)) u_edge_ram (
        .i_clk(i_clk), .i_wr_en(w_e_we), .i_wr_addr(w_e_waddr), .i_wr_data(w_e_wdata),
        .i_rd_addr(w_e_raddr), .o_rd_data(w_e_rdata)
    );

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.ancestor = r_out_anc;
    assign w_acc          = i_req.valid && (r_state == S_IDLE);

    assign w_n = (32'(r_node_count) > MAX_NODES) ? NODE_W'(MAX_NODES) : r_node_count;
    assign w_q_bad = (i_req.node_a == '0) || (i_req.node_b == '0)
                   || (i_req.node_a > w_n) || (i_req.node_b > w_n);

    // edge endpoint selection during the walk
    assign w_ea = w_e_rdata[2*NODE_W-1:NODE_W];
    assign w_eb = w_e_rdata[NODE_W-1:0];
    always_comb begin
        w_e_ok = 1'b0;
        w_ey   = w_ea;
        if (w_ea != '0 && w_eb != '0 && w_ea <= w_n && w_eb <= w_n) begin
            if (w_ea == r_x) begin
                w_e_ok = 1'b1;
                w_ey   = w_eb;
            end else if (w_eb == r_x) begin
                w_e_ok = 1'b1;
                w_ey   = w_ea;
            end
        end
    end
    assign w_push = (r_state == S_E2) && !w_nd_rdata[DW] && (r_tail < QCW'(MAX_NODES));

    // query climb
    assign w_step     = CMPW'(1) << r_qi;
    assign w_lift_go  = CMPW'(r_du) >= (CMPW'(r_dv) + w_step);
    assign w_up       = row_field(r_row_u, r_qi);
    assign w_pu       = row_field(r_row_u, r_qi);
    assign w_pv       = row_field(r_row_v, r_qi);
    assign w_climb_go = (w_pu != '0) && (w_pu != w_pv)
                      && (32'(w_pu) <= MAX_NODES) && (32'(w_pv) <= MAX_NODES);
    assign w_log      = top_level(r_du);

    // ancestor fill
    assign w_mid  = row_field(w_lt_rdata, LWI'(r_fj - 1'b1));
    assign w_fmid = row_field(w_lt_rdata, LWI'(r_fj - 1'b1));
    always_comb begin
        w_fill_row = r_row_u;
        w_fill_row[NODE_W*LWI'(r_fj) +: NODE_W] = w_fmid;
    end

    always_comb begin
        w_nd_we    = 1'b0;
        w_nd_waddr = r_ci;
        w_nd_wdata = '0;
        w_nd_raddr = '0;
        w_lt_we    = 1'b0;
        w_lt_waddr = r_ci;
        w_lt_wdata = '0;
        w_lt_raddr = '0;
        w_q_we     = 1'b0;
        w_q_waddr  = QAW'(r_tail);
        w_q_wdata  = r_y;
        w_q_raddr  = QAW'(r_head);
        w_e_we     = 1'b0;
        w_e_waddr  = EAW'(r_edges);
        w_e_wdata  = {i_req.node_a, i_req.node_b};
        w_e_raddr  = EAW'(r_e);
        case (r_state)
            S_IDLE: begin
                w_e_we     = w_acc && (i_req.cmd == CMD_ADD_EDGE)
                           && (r_edges < EW'(MAX_NODES - 1));
                w_nd_raddr = AW'(i_req.node_a);
                w_lt_raddr = AW'(i_req.node_a);
            end
            S_CLR: begin
                w_nd_we = 1'b1;
                w_lt_we = 1'b1;
            end
            S_ROOT: begin
                w_nd_we    = 1'b1;
                w_nd_waddr = AW'(1);
                w_nd_wdata = {1'b1, DW'(0)};
                w_q_we     = 1'b1;
                w_q_waddr  = '0;
                w_q_wdata  = NODE_W'(1);
            end
            S_X1:  w_nd_raddr = AW'(w_q_rdata);
            S_E1:  w_nd_raddr = AW'(w_ey);
            S_E2: begin
                w_nd_we    = w_push;
                w_nd_waddr = AW'(r_y);
                w_nd_wdata = {1'b1, r_dx + 1'b1};
                w_lt_we    = w_push;
                w_lt_waddr = AW'(r_y);
                w_lt_wdata = RW'(r_x);
                w_q_we     = w_push;
            end
            S_FI:    w_lt_raddr = AW'(r_fi);
            S_F1:    w_lt_raddr = AW'(w_mid);
            S_F2: begin
                w_lt_we    = 1'b1;
                w_lt_waddr = AW'(r_fi);
                w_lt_wdata = w_fill_row;
            end
            S_QB: begin
                w_nd_raddr = AW'(r_v);
                w_lt_raddr = AW'(r_v);
            end
            S_LIFT:  w_lt_raddr = AW'(w_up);
            S_CLIMB: w_lt_raddr = AW'(w_pu);
            S_CW1:   w_lt_raddr = AW'(r_v);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_node_count <= NODE_W'(1024);
            r_edges      <= '0;
            r_ci         <= '0;
            r_walk       <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_node_count <= i_cfg_wr_data;
            // a pending result in S_QDONE refills the output register itself
            if (r_out_valid && o_rsp.ready && r_state != S_QDONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_req.cmd)
                            CMD_ADD_EDGE: begin
                                if (r_edges < EW'(MAX_NODES - 1)) r_edges <= r_edges + 1'b1;
                            end
                            CMD_BUILD: begin
                                r_ci    <= '0;
                                r_walk  <= 1'b1;
                                r_state <= S_CLR;
                            end
                            CMD_QUERY: begin
                                r_u <= i_req.node_a;
                                r_v <= i_req.node_b;
                                if (w_q_bad) begin
                                    r_res   <= '0;
                                    r_state <= S_QDONE;
                                end else begin
                                    r_state <= S_QB;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == AW'(MAX_NODES)) begin
                        r_state <= (r_walk && w_n != '0) ? S_ROOT : S_IDLE;
                    end
                end
                S_ROOT: begin
                    r_head  <= '0;
                    r_tail  <= QCW'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + 1'b1;
                        r_state <= S_X1;
                    end else begin
                        r_fj    <= LJW'(1);
                        r_state <= S_FJ;
                    end
                end
                S_X1: begin
                    r_x     <= w_q_rdata;
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_dx    <= w_nd_rdata[DW-1:0];
                    r_e     <= '0;
                    r_state <= S_E;
                end
                S_E: begin
                    if (r_e < r_edges) begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_E1;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_E1: begin
                    r_y     <= w_ey;
                    r_state <= w_e_ok ? S_E2 : S_E;
                end
                S_E2: begin
                    if (w_push) r_tail <= r_tail + 1'b1;
                    r_state <= S_E;
                end
                S_FJ: begin
                    if ((32'(r_fj) < LEVELS) && ((SHW'(1) << r_fj) < SHW'(w_n))) begin
                        r_fi    <= (NODE_W + 1)'(1);
                        r_state <= S_FI;
                    end else begin
                        r_walk  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_FI: begin
                    if (r_fi <= (NODE_W + 1)'(w_n)) begin
                        r_state <= S_F1;
                    end else begin
                        r_fj    <= r_fj + 1'b1;
                        r_state <= S_FJ;
                    end
                end
                S_F1: begin
                    r_row_u <= w_lt_rdata;
                    if (w_mid != '0 && 32'(w_mid) <= MAX_NODES) begin
                        r_state <= S_F2;
                    end else begin
                        r_fi    <= r_fi + 1'b1;
                        r_state <= S_FI;
                    end
                end
                S_F2: begin
                    r_fi    <= r_fi + 1'b1;
                    r_state <= S_FI;
                end
                S_QB: begin
                    r_du    <= w_nd_rdata[DW-1:0];
                    r_row_u <= w_lt_rdata;
                    r_state <= S_QC;
                end
                S_QC: begin
                    // put the deeper node in u
                    if (r_du < w_nd_rdata[DW-1:0]) begin
                        r_u     <= r_v;
                        r_v     <= r_u;
                        r_du    <= w_nd_rdata[DW-1:0];
                        r_dv    <= r_du;
                        r_row_u <= w_lt_rdata;
                        r_row_v <= r_row_u;
                    end else begin
                        r_dv    <= w_nd_rdata[DW-1:0];
                        r_row_v <= w_lt_rdata;
                    end
                    r_state <= S_QT;
                end
                S_QT: begin
                    r_top   <= w_log;
                    r_qi    <= w_log;
                    r_state <= S_LIFT;
                end
                S_LIFT: begin
                    if (w_lift_go) begin
                        if (w_up == '0 || 32'(w_up) > MAX_NODES) begin
                            r_res   <= '0;
                            r_state <= S_QDONE;
                        end else begin
                            r_u     <= w_up;
                            r_du    <= r_du - DW'(w_step);
                            r_fin   <= (r_qi == '0);
                            if (r_qi != '0) r_qi <= r_qi - 1'b1;
                            r_state <= S_LWAIT;
                        end
                    end else if (r_qi == '0) begin
                        r_state <= S_EQ;
                    end else begin
                        r_qi <= r_qi - 1'b1;
                    end
                end
                S_LWAIT: begin
                    r_row_u <= w_lt_rdata;
                    r_state <= r_fin ? S_EQ : S_LIFT;
                end
                S_EQ: begin
                    if (r_u == r_v) begin
                        r_res   <= r_u;
                        r_state <= S_QDONE;
                    end else begin
                        r_qi    <= r_top;
                        r_state <= S_CLIMB;
                    end
                end
                S_CLIMB: begin
                    if (w_climb_go) begin
                        r_u     <= w_pu;
                        r_v     <= w_pv;
                        r_fin   <= (r_qi == '0);
                        if (r_qi != '0) r_qi <= r_qi - 1'b1;
                        r_state <= S_CW1;
                    end else if (r_qi == '0) begin
                        r_state <= S_QEND;
                    end else begin
                        r_qi <= r_qi - 1'b1;
                    end
                end
                S_CW1: begin
                    r_row_u <= w_lt_rdata;
                    r_state <= S_CW2;
                end
                S_CW2: begin
                    r_row_v <= w_lt_rdata;
                    r_state <= r_fin ? S_QEND : S_CLIMB;
                end
                S_QEND: begin
                    r_res   <= row_field(r_row_u, '0);
                    r_state <= S_QDONE;
                end
                S_QDONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_anc   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "tree_lca_binary_lifting_macros.svh"

    `TLCA_ASSERT_NOW(a_queue_order, i_clk, i_rst_n, 1'b1, r_head <= r_tail, "walk queue head passed tail")
    `TLCA_ASSERT_NOW(a_edge_bound, i_clk, i_rst_n, 1'b1, r_edges <= EW'(MAX_NODES - 1), "edge count overflow")
    `TLCA_ASSERT_NOW(a_rsp_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_QDONE, "result without a query")
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for tree_lca_binary_lifting: streams edge, build and query
// transfers and checks each returned ancestor against a behavioral tree model.
// Depends on tlca_pkg, tlca_if and the tree_lca_binary_lifting RTL.
`timescale 1ns / 1ps
module testbench;
    import tlca_pkg::*;

    localparam int MAX_NODES   = 1024;
    localparam int LEVELS      = 10;
    localparam int MAX_EDGES   = MAX_NODES - 1;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct packed {
        t_cmd  cmd;
        t_node node_a;
        t_node node_b;
    } t_request;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_wr_en;
    t_node i_cfg_wr_data;

    tlca_in_if  req_if();
    tlca_out_if rsp_if();

    tree_lca_binary_lifting #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    // Tree model state
    int unsigned node_limit;
    int unsigned edge_u [MAX_EDGES];
    int unsigned edge_v [MAX_EDGES];
    int unsigned edge_total;
    int unsigned depth_of [MAX_NODES+1];
    bit          visited [MAX_NODES+1];
    int unsigned lift [MAX_NODES+1][LEVELS];

    t_request pending_requests[$];
    t_node    lca_expected[$];
    int       mismatch_count;
    int       tx_idle_pct;
    int       rx_idle_pct;
    logic     rx_block;
    longint   cycle_count;

    function automatic int unsigned active_nodes();
        return node_limit > MAX_NODES ? MAX_NODES : node_limit;
    endfunction

    function automatic void build_tree();
        int unsigned n, head, tail, x, a, b, y, mid;
        int unsigned walk [MAX_NODES];
        n = active_nodes();
        head = 0;
        tail = 0;
        for (int i = 0; i <= MAX_NODES; i++) begin
            visited[i] = 0;
            depth_of[i] = 0;
            for (int j = 0; j < LEVELS; j++) lift[i][j] = 0;
        end
        if (n == 0) return;
        walk[tail++] = 1;
        visited[1] = 1;
        while (head < tail) begin
            x = walk[head++];
            for (int e = 0; e < edge_total; e++) begin
                a = edge_u[e];
                b = edge_v[e];
                if (a == 0 || b == 0 || a > n || b > n) continue;
                if (a == x) y = b;
                else if (b == x) y = a;
                else continue;
                if (!visited[y] && tail < MAX_NODES) begin
                    visited[y] = 1;
                    depth_of[y] = depth_of[x] + 1;
                    lift[y][0] = x;
                    walk[tail++] = y;
                end
            end
        end
        for (int j = 1; j < LEVELS && (64'd1 << j) < n; j++) begin
            for (int i = 1; i <= n; i++) begin
                mid = lift[i][j-1];
                if (mid != 0 && mid <= MAX_NODES) lift[i][j] = lift[mid][j-1];
            end
        end
    endfunction

    function automatic t_node lowest_ancestor(int unsigned u, int unsigned v);
        int unsigned n, top, t, up, pu, pv;
        n = active_nodes();
        if (u == 0 || v == 0 || u > n || v > n) return '0;
        if (depth_of[u] < depth_of[v]) begin
            t = u;
            u = v;
            v = t;
        end
        top = 0;
        while (top + 1 < 32 && (64'd1 << (top + 1)) <= depth_of[u]) top++;
        if (top > LEVELS - 1) top = LEVELS - 1;
        for (int i = top; i >= 0; i--) begin
            if (64'(depth_of[u]) >= 64'(depth_of[v]) + (64'd1 << i)) begin
                up = lift[u][i];
                if (up == 0 || up > MAX_NODES) return '0;
                u = up;
            end
        end
        if (u == v) return t_node'(u);
        for (int i = top; i >= 0; i--) begin
            pu = lift[u][i];
            pv = lift[v][i];
            if (pu != 0 && pu != pv && pu <= MAX_NODES && pv <= MAX_NODES) begin
                u = pu;
                v = pv;
            end
        end
        return t_node'(lift[u][0]);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 30) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tree_lca_binary_lifting verification failed");
            $finish;
        end
    end

    // Driver: update the model on each accepted transfer, then offer the next item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                case (req_if.cmd)
                    CMD_ADD_EDGE: begin
                        if (edge_total < MAX_EDGES) begin
                            edge_u[edge_total] = req_if.node_a;
                            edge_v[edge_total] = req_if.node_b;
                            edge_total++;
                        end
                    end
                    CMD_BUILD: build_tree();
                    CMD_QUERY: lca_expected = {lca_expected,
                        lowest_ancestor(req_if.node_a, req_if.node_b)};
                    default: ;
                endcase
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    t_request r;
                    r = pending_requests.pop_front();
                    req_if.cmd    <= r.cmd;
                    req_if.node_a <= r.node_a;
                    req_if.node_b <= r.node_b;
                    req_if.valid  <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (lca_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected ancestor %0d", rsp_if.ancestor));
                end else begin
                    t_node want;
                    want = lca_expected.pop_front();
                    if (rsp_if.ancestor !== want)
                        report_mismatch($sformatf("ancestor %0d, expected %0d",
                                                  rsp_if.ancestor, want));
                end
            end
            rsp_if.ready <= !rx_block && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send(input t_cmd c, input int unsigned a, input int unsigned b);
        t_request r;
        r.cmd = c;
        r.node_a = t_node'(a);
        r.node_b = t_node'(b);
        pending_requests = {pending_requests, r};
    endtask

    // Mostly well-formed nodes; some zero, some beyond the count, some unused commands.
    task automatic send_queries(input int count, input int unsigned span);
        int unsigned a, b;
        int pick;
        for (int k = 0; k < count; k++) begin
            a = $urandom_range(1, span);
            b = $urandom_range(1, span);
            pick = $urandom_range(99);
            if (pick < 4) a = 0;
            else if (pick < 9) b = $urandom_range(0, 2047);
            else if (pick < 12) begin
                send(CMD_NONE, $urandom_range(0, 2047), $urandom_range(0, 2047));
                continue;
            end
            send(CMD_QUERY, a, b);
        end
        send(CMD_QUERY, $urandom_range(1, span), $urandom_range(1, span));
    endtask

    // Random tree over nodes 1..count+1, endpoint order shuffled.
    task automatic send_tree(input int unsigned count);
        int unsigned parent;
        for (int unsigned k = 2; k <= count + 1; k++) begin
            parent = $urandom_range(1, k - 1);
            if ($urandom_range(1)) send(CMD_ADD_EDGE, k, parent);
            else send(CMD_ADD_EDGE, parent, k);
        end
    endtask

    task automatic drain_and_set(input int unsigned count, input int mode);
        while (pending_requests.size() > 0 || req_if.valid || lca_expected.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= t_node'(count);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        node_limit = count & 11'h7FF;
        tx_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 67 : 0;
        rx_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 11 : 0;
    endtask

    initial begin
        int unsigned prev, next;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_NONE;
        req_if.node_a = '0;
        req_if.node_b = '0;
        rsp_if.ready = 1'b0;
        rx_block = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        edge_total = 0;
        node_limit = 1024;
        tx_idle_pct = 11;
        rx_idle_pct = 67;
        for (int i = 0; i <= MAX_NODES; i++) begin
            depth_of[i] = 0;
            visited[i] = 0;
            for (int j = 0; j < LEVELS; j++) lift[i][j] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: queries on cleared tables, empty build, bad endpoints, extremes.
        send(CMD_QUERY, 1, 1);
        send(CMD_QUERY, 0, 5);
        send(CMD_QUERY, 2047, 3);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 1, 1);
        send(CMD_ADD_EDGE, 1, 2);
        send(CMD_ADD_EDGE, 3, 1);
        send(CMD_ADD_EDGE, 2, 1024);
        send(CMD_ADD_EDGE, 1024, 1023);
        send(CMD_ADD_EDGE, 3, 0);
        send(CMD_ADD_EDGE, 1025, 2);
        send(CMD_ADD_EDGE, 2047, 1023);
        send(CMD_ADD_EDGE, 5, 6);
        send(CMD_NONE, 2047, 2047);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 1023, 3);
        send(CMD_QUERY, 1024, 1023);
        send(CMD_QUERY, 1023, 1024);
        send(CMD_QUERY, 5, 6);
        send(CMD_QUERY, 1024, 2);
        send(CMD_QUERY, 1025, 1);
        send(CMD_QUERY, 2047, 0);

        drain_and_set(16, 0);
        send_tree(15);
        send(CMD_BUILD, 0, 0);
        send_queries(60, 18);

        drain_and_set(1, 1);
        send(CMD_ADD_EDGE, 1, 2);
        send(CMD_BUILD, 0, 0);
        send_queries(20, 3);

        drain_and_set(0, 2);
        send(CMD_BUILD, 0, 0);
        send_queries(15, 4);

        // Clamped count; a deep chain through scattered labels, built twice.
        drain_and_set(2047, 0);
        prev = 1;
        for (int k = 0; k < 80; k++) begin
            next = 100 + k * 11 + $urandom_range(0, 10);
            send(CMD_ADD_EDGE, prev, next);
            prev = next;
        end
        send(CMD_BUILD, 0, 0);
        send_queries(40, 1024);
        for (int k = 0; k < 60; k++)
            send(CMD_QUERY, 100 + $urandom_range(0, 79) * 11 + $urandom_range(0, 10),
                 100 + $urandom_range(0, 79) * 11 + $urandom_range(0, 10));
        send(CMD_BUILD, 0, 0);
        send_queries(20, 1024);

        // Hold the receiver once queries flow so the block backs up its input.
        drain_and_set(64, 1);
        send_tree(63);
        send(CMD_BUILD, 0, 0);
        send_queries(100, 66);
        while (lca_expected.size() == 0)
            @(posedge i_clk);
        rx_block <= 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                rx_block <= 1'b0;
            end
        join_none

        // Edges added after the build only take effect at the rebuild.
        drain_and_set(200, 2);
        send_tree(100);
        send(CMD_BUILD, 0, 0);
        send_queries(100, 200);
        send_tree(40);
        send_queries(40, 200);
        send(CMD_BUILD, 0, 0);
        send_queries(100, 200);

        // Small count over the stored edges plus a few with bad endpoints.
        drain_and_set(8, 0);
        send(CMD_ADD_EDGE, 0, 5);
        send(CMD_ADD_EDGE, 2047, 3);
        send(CMD_ADD_EDGE, 1, 6);
        send(CMD_ADD_EDGE, 6, 7);
        send(CMD_ADD_EDGE, 2, 6);
        send(CMD_ADD_EDGE, 7, 8);
        send(CMD_ADD_EDGE, 1, 3);
        send(CMD_BUILD, 0, 0);
        send_queries(40, 9);

        while (pending_requests.size() > 0 || req_if.valid || lca_expected.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tree_lca_binary_lifting verification clean");
        end else begin
            $display("tree_lca_binary_lifting verification failed");
        end
        $finish;
    end
endmodule
